/* src/dpft_pkg.sv */
// ----------------------------------------------------------------------------
// dpft_pkg
// shared widths and parameter defaults for the demand page frame translator
// ----------------------------------------------------------------------------
package dpft_pkg;

  localparam int IN_ADDR_BITS   = 32;
  localparam int PAGE_BITS      = 20;
  localparam int PHYS_BITS      = 20;
  localparam int FRAME_OUT_BITS = 8;

  localparam int DEF_OFFSET_BITS  = 12;
  localparam int DEF_ADDRESS_BITS = 32;
  localparam int DEF_FRAME_COUNT  = 256;

endpackage

/* src/dpft_table.sv */
// ----------------------------------------------------------------------------
// dpft_table
// frame to page memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module dpft_table
  import dpft_pkg::*;
#(
  parameter int FRAME_COUNT = DEF_FRAME_COUNT,
  localparam int FW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [FW-1:0]        waddr,
  input  logic [PAGE_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [FW-1:0]        raddr,
  output logic [PAGE_BITS-1:0] rdata
);

  logic [PAGE_BITS-1:0] mem [FRAME_COUNT];
  logic [PAGE_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/demand_page_frame_translator.sv */
// ----------------------------------------------------------------------------
// demand_page_frame_translator
// translates a logical address to a frame address, allocating frames in order
// the scan reads the frames in use in order and ends at the first match; a miss
// or fault is reported once all N frames are read, N being the number of frames in use
// busy drops on the edge that loads the result, so a new start can be presented
// while the result strobe is high; the receiver cannot stall
// the table scan is set by the single read port, one entry a cycle
// synchronous reset clears the frame count, no table clearing pass is needed
// ----------------------------------------------------------------------------
module demand_page_frame_translator
  import dpft_pkg::*;
#(
  parameter int OFFSET_BITS  = DEF_OFFSET_BITS,
  parameter int ADDRESS_BITS = DEF_ADDRESS_BITS,
  parameter int FRAME_COUNT  = DEF_FRAME_COUNT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [IN_ADDR_BITS-1:0]   in_logical_address,
  output logic                      out_valid,
  output logic [PHYS_BITS-1:0]      out_physical_address,
  output logic [FRAME_OUT_BITS-1:0] out_frame_number,
  output logic                      out_newly_assigned,
  output logic                      out_fault
);

  localparam int FW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int CW = $clog2(FRAME_COUNT + 1);
  localparam logic [IN_ADDR_BITS-1:0] ADDR_MASK = (ADDRESS_BITS >= IN_ADDR_BITS) ? '1 :
      IN_ADDR_BITS'((64'd1 << ADDRESS_BITS) - 64'd1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            used_r, used_nxt;
  logic [CW-1:0]            rd_idx_r, rd_idx_nxt;
  logic                     cmp_vld_r, cmp_vld_nxt;
  logic [FW-1:0]            cmp_idx_r, cmp_idx_nxt;
  logic [PAGE_BITS-1:0]     page_r, page_nxt;
  logic [OFFSET_BITS-1:0]   offset_r, offset_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [PHYS_BITS-1:0]      out_phys_r, out_phys_nxt;
  logic [FRAME_OUT_BITS-1:0] out_frame_r, out_frame_nxt;
  logic                      out_new_r, out_new_nxt;
  logic                      out_fault_r, out_fault_nxt;

  logic [IN_ADDR_BITS-1:0]  addr_masked;
  logic                     issue;
  logic                     match;
  logic                     table_full;
  logic [FW-1:0]            frame_sel;
  logic [63:0]              phys_full;
  logic                     we;
  logic [PAGE_BITS-1:0]     rdata;

  assign addr_masked = in_logical_address & ADDR_MASK;
  assign issue       = (state_r == ST_SCAN) && (rd_idx_r < used_r);
  assign match       = (state_r == ST_SCAN) && cmp_vld_r && (rdata == page_r);
  assign table_full  = (used_r == CW'(FRAME_COUNT));
  assign frame_sel   = match ? cmp_idx_r : used_r[FW-1:0];
  assign phys_full   = (64'(frame_sel) << OFFSET_BITS) | 64'(offset_r);

  dpft_table #(
    .FRAME_COUNT(FRAME_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (used_r[FW-1:0]),
    .wdata (page_r),
    .re    (issue),
    .raddr (rd_idx_r[FW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    page_nxt      = page_r;
    offset_nxt    = offset_r;
    out_valid_nxt = 1'b0;
    out_phys_nxt  = out_phys_r;
    out_frame_nxt = out_frame_r;
    out_new_nxt   = out_new_r;
    out_fault_nxt = out_fault_r;
    we            = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          page_nxt   = PAGE_BITS'(addr_masked >> OFFSET_BITS);
          offset_nxt = addr_masked[OFFSET_BITS-1:0];
          rd_idx_nxt = '0;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          rd_idx_nxt  = CW'(rd_idx_r + 1'b1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r[FW-1:0];
        end
        if (match) begin
          out_valid_nxt = 1'b1;
          out_phys_nxt  = phys_full[PHYS_BITS-1:0];
          out_frame_nxt = FRAME_OUT_BITS'(frame_sel);
          out_new_nxt   = 1'b0;
          out_fault_nxt = 1'b0;
          cmp_vld_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
        end else if (!issue) begin
          out_valid_nxt = 1'b1;
          if (table_full) begin
            out_phys_nxt  = '0;
            out_frame_nxt = '0;
            out_new_nxt   = 1'b0;
            out_fault_nxt = 1'b1;
          end else begin
            we            = 1'b1;
            used_nxt      = CW'(used_r + 1'b1);
            out_phys_nxt  = phys_full[PHYS_BITS-1:0];
            out_frame_nxt = FRAME_OUT_BITS'(frame_sel);
            out_new_nxt   = 1'b1;
            out_fault_nxt = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r    <= rd_idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    page_r      <= page_nxt;
    offset_r    <= offset_nxt;
    out_phys_r  <= out_phys_nxt;
    out_frame_r <= out_frame_nxt;
    out_new_r   <= out_new_nxt;
    out_fault_r <= out_fault_nxt;
  end

  assign busy                 = (state_r != ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_physical_address = out_phys_r;
  assign out_frame_number     = out_frame_r;
  assign out_newly_assigned   = out_new_r;
  assign out_fault            = out_fault_r;

endmodule

/* test/frame_check_pkg.sv */
// ----------------------------------------------------------------------------
// frame_check_pkg
// frame allocation predictor and result checker for the page translator bench
// ----------------------------------------------------------------------------
package frame_check_pkg;
  import dpft_pkg::*;

  localparam int OFFSET_W    = DEF_OFFSET_BITS;
  localparam int FRAME_TOTAL = DEF_FRAME_COUNT;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [PHYS_BITS-1:0]      phys;
    logic [FRAME_OUT_BITS-1:0] frame;
    logic                      fresh;
    logic                      fault;
  } xlate_t;

  class frame_scoreboard;
    logic [PAGE_BITS-1:0] page_of_frame[FRAME_TOTAL];
    int unsigned          frames_used = 0;
    xlate_t               xlate_q[$];
    int unsigned          failures = 0;

    function void flag(string msg);
      failures++;
      if (failures <= REPORT_MAX) $display("%s", msg);
    endfunction

    function int unsigned pending();
      return xlate_q.size();
    endfunction

    // translate one accepted address and update the allocation state
    function void log_request(logic [IN_ADDR_BITS-1:0] addr);
      logic [PAGE_BITS-1:0] page;
      logic [OFFSET_W-1:0]  offs;
      xlate_t               want;
      int                   hit_frame;
      int                   k;
      page      = addr[IN_ADDR_BITS-1:OFFSET_W];
      offs      = addr[OFFSET_W-1:0];
      hit_frame = -1;
      k         = 0;
      while (hit_frame < 0 && k < frames_used) begin
        if (page_of_frame[k] == page) hit_frame = k;
        k++;
      end
      want = '0;
      if (hit_frame >= 0) begin
        want.phys  = (PHYS_BITS'(hit_frame) << OFFSET_W) + PHYS_BITS'(offs);
        want.frame = FRAME_OUT_BITS'(hit_frame);
      end else if (frames_used >= FRAME_TOTAL) begin
        want.fault = 1'b1;
      end else begin
        page_of_frame[frames_used] = page;
        want.phys  = (PHYS_BITS'(frames_used) << OFFSET_W) + PHYS_BITS'(offs);
        want.frame = FRAME_OUT_BITS'(frames_used);
        want.fresh = 1'b1;
        frames_used++;
      end
      xlate_q.push_back(want);
    endfunction

    function void check_translation(logic [PHYS_BITS-1:0] phys,
                                    logic [FRAME_OUT_BITS-1:0] frame,
                                    logic fresh, logic fault);
      xlate_t want;
      if (xlate_q.size() == 0) begin
        flag($sformatf("result beat with nothing pending: phys %05h frame %0d", phys, frame));
        return;
      end
      want = xlate_q.pop_front();
      if (phys !== want.phys)
        flag($sformatf("physical_address mismatch: expected %05h, got %05h", want.phys, phys));
      if (frame !== want.frame)
        flag($sformatf("frame_number mismatch: expected %0d, got %0d", want.frame, frame));
      if (fresh !== want.fresh)
        flag($sformatf("newly_assigned mismatch: expected %0b, got %0b", want.fresh, fresh));
      if (fault !== want.fault)
        flag($sformatf("fault mismatch: expected %0b, got %0b", want.fault, fault));
    endfunction

    function void close_out();
      while (xlate_q.size() != 0) begin
        void'(xlate_q.pop_front());
        flag("expected result never arrived");
      end
    endfunction
  endclass

endpackage

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// drives logical addresses into the page frame translator and checks every
// translation against a frame allocation predictor: directed corner addresses
// first, then random hits, fresh pages and table-full faults with random gaps
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dpft_pkg::*;
  import frame_check_pkg::*;

  localparam int RANDOM_ITEMS   = 1150;
  localparam int QUIET_FIRST    = 300;
  localparam int QUIET_LAST     = 500;
  localparam int DRAIN_AT       = 650;
  localparam int TAIL_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [IN_ADDR_BITS-1:0]   in_logical_address = '0;
  logic                      out_valid;
  logic [PHYS_BITS-1:0]      out_physical_address;
  logic [FRAME_OUT_BITS-1:0] out_frame_number;
  logic                      out_newly_assigned;
  logic                      out_fault;

  frame_scoreboard board = new;

  demand_page_frame_translator i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_logical_address   (in_logical_address),
    .out_valid            (out_valid),
    .out_physical_address (out_physical_address),
    .out_frame_number     (out_frame_number),
    .out_newly_assigned   (out_newly_assigned),
    .out_fault            (out_fault)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      board.check_translation(out_physical_address, out_frame_number,
                              out_newly_assigned, out_fault);
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((rst_n && start && busy === 1'b0) || out_valid === 1'b1) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // start stays high between back-to-back beats
  task automatic send_address(input logic [IN_ADDR_BITS-1:0] addr, input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_logical_address <= addr;
    do @(posedge clk); while (busy !== 1'b0);
    board.log_request(addr);
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  function automatic int unsigned pick_gap(int idx);
    if (idx >= QUIET_FIRST && idx < QUIET_LAST) return 0;
    if ($urandom_range(99) < 15) return $urandom_range(8, 1);
    return 0;
  endfunction

  // mostly pages already held or fresh random pages, some offset corners
  function automatic logic [IN_ADDR_BITS-1:0] pick_address();
    int unsigned          roll;
    logic [PAGE_BITS-1:0] page;
    logic [OFFSET_W-1:0]  offs;
    roll = $urandom_range(99);
    if (board.frames_used == 0 || roll >= 55) return $urandom;
    page = board.page_of_frame[$urandom_range(board.frames_used - 1)];
    if (roll < 45) offs = OFFSET_W'($urandom);
    else offs = roll[0] ? '1 : '0;
    return {page, offs};
  endfunction

  initial begin : stimulus
    logic [IN_ADDR_BITS-1:0] directed_addrs[$];
    directed_addrs = '{32'h0000_0000, 32'h0000_0FFF, 32'hFFFF_FFFF, 32'hFFFF_F000,
                       32'h0000_1000, 32'h0000_0800, 32'h8000_0ABC, 32'h7FFF_F555,
                       32'hAAAA_A555, 32'h5555_5AAA, 32'hFFFF_E001, 32'h0000_1FFF,
                       32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000, 32'h0000_0001};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_addrs[i])
      send_address(directed_addrs[i], (i % 4 == 3) ? 2 : 0);
    wait_all_results();
    @(posedge clk);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == DRAIN_AT) wait_all_results();
      send_address(pick_address(), pick_gap(n));
    end

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    board.close_out();
    if (board.failures == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
